### hdl/hsr_pkg.sv
package hsr_pkg;
    localparam int WORD_W = 32;
    localparam logic [WORD_W-1:0] WORD_MAX = '1;
endpackage

### hdl/heron_square_root_core.sv
// Heron square root of an unsigned fixed-point word (FRAC_BITS fraction bits).
// Fully pipelined chain of cells: each Heron step is 32+FRAC_BITS restoring
// divide cells (one quotient bit each) and one averaging cell. One word is
// taken every cycle while the output is not stalled. A stalled output
// freezes the whole chain.
module heron_square_root_core #(
    parameter int ITERATIONS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] radicand,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] root
);
    localparam int W  = hsr_pkg::WORD_W;
    localparam int DW = W + FRAC_BITS;
    localparam int SW = DW + 1;
    localparam int N  = ITERATIONS * SW;

    logic          en;
    logic          n_vld [0:N];
    logic [W-1:0]  n_rad [0:N];
    logic [W-1:0]  n_div [0:N];
    logic [W-1:0]  n_rem [0:N];
    logic [W-1:0]  n_quo [0:N];
    logic          n_ovf [0:N];

    assign en       = !n_vld[N] || out_ready;
    assign in_ready = en;

    // start estimate: radicand halved; zero is lifted to one inside the cells
    assign n_vld[0] = in_valid;
    assign n_rad[0] = radicand;
    assign n_div[0] = {1'b0, radicand[W-1:1]};
    assign n_rem[0] = '0;
    assign n_quo[0] = '0;
    assign n_ovf[0] = 1'b0;

    genvar k, j;
    generate
        for (k = 0; k < ITERATIONS; k++)
        begin : g_iter
            for (j = 0; j < DW; j++)
            begin : g_bit
                hsr_div_cell #(
                    .BIT_IDX   (DW - 1 - j),
                    .FRAC_BITS (FRAC_BITS)
                ) u_div (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .en      (en),
                    .in_vld  (n_vld[k*SW+j]),
                    .in_rad  (n_rad[k*SW+j]),
                    .in_div  (n_div[k*SW+j]),
                    .in_rem  (n_rem[k*SW+j]),
                    .in_quo  (n_quo[k*SW+j]),
                    .in_ovf  (n_ovf[k*SW+j]),
                    .out_vld (n_vld[k*SW+j+1]),
                    .out_rad (n_rad[k*SW+j+1]),
                    .out_div (n_div[k*SW+j+1]),
                    .out_rem (n_rem[k*SW+j+1]),
                    .out_quo (n_quo[k*SW+j+1]),
                    .out_ovf (n_ovf[k*SW+j+1])
                );
            end

            hsr_avg_cell u_avg (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .in_vld  (n_vld[k*SW+DW]),
                .in_rad  (n_rad[k*SW+DW]),
                .in_div  (n_div[k*SW+DW]),
                .in_quo  (n_quo[k*SW+DW]),
                .in_ovf  (n_ovf[k*SW+DW]),
                .out_vld (n_vld[(k+1)*SW]),
                .out_rad (n_rad[(k+1)*SW]),
                .out_est (n_div[(k+1)*SW])
            );
            assign n_rem[(k+1)*SW] = '0;
            assign n_quo[(k+1)*SW] = '0;
            assign n_ovf[(k+1)*SW] = 1'b0;
        end
    endgenerate

    assign out_valid = n_vld[N];
    assign root      = n_div[N];

`ifndef ASSERT_OFF
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_vld[DW] |-> (n_rem[DW] < n_div[DW]))
        else $error("remainder not below divisor after first divide");

    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(n_vld[SW]) && $stable(n_div[SW])))
        else $error("chain moved while output stalled");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while chain stalled");
`endif
endmodule

### hdl/hsr_div_cell.sv
module hsr_div_cell #(
    parameter int BIT_IDX   = 0,
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [hsr_pkg::WORD_W-1:0]    in_rad,
    input  logic [hsr_pkg::WORD_W-1:0]    in_div,
    input  logic [hsr_pkg::WORD_W-1:0]    in_rem,
    input  logic [hsr_pkg::WORD_W-1:0]    in_quo,
    input  logic                          in_ovf,
    output logic                          out_vld,
    output logic [hsr_pkg::WORD_W-1:0]    out_rad,
    output logic [hsr_pkg::WORD_W-1:0]    out_div,
    output logic [hsr_pkg::WORD_W-1:0]    out_rem,
    output logic [hsr_pkg::WORD_W-1:0]    out_quo,
    output logic                          out_ovf
);
    localparam int W = hsr_pkg::WORD_W;

    logic          vld_reg;
    logic [W-1:0]  rad_reg, div_reg, rem_reg, quo_reg;
    logic          ovf_reg;
    logic [W-1:0]  dvs;
    logic          dbit;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;
    logic [W-1:0]  rem_next, quo_next;
    logic          ovf_next;

    // divisor never below one raw unit
    assign dvs = (in_div == '0) ? W'(1) : in_div;

    generate
        if (BIT_IDX >= FRAC_BITS) begin : g_dbit
            assign dbit = in_rad[BIT_IDX-FRAC_BITS];
        end else begin : g_dzero
            assign dbit = 1'b0;
        end
    endgenerate

    assign trial    = {in_rem, dbit};
    assign ge       = (trial >= {1'b0, dvs});
    assign diff     = trial - {1'b0, dvs};
    assign rem_next = ge ? diff[W-1:0] : trial[W-1:0];

    // quotient bits above the word only mark saturation
    generate
        if (BIT_IDX >= W) begin : g_hi
            assign quo_next = in_quo;
            assign ovf_next = in_ovf | ge;
        end else begin : g_lo
            assign quo_next = {in_quo[W-2:0], ge};
            assign ovf_next = in_ovf;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= in_rad;
            div_reg <= dvs;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            ovf_reg <= ovf_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_rad = rad_reg;
    assign out_div = div_reg;
    assign out_rem = rem_reg;
    assign out_quo = quo_reg;
    assign out_ovf = ovf_reg;
endmodule

### hdl/hsr_avg_cell.sv
module hsr_avg_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [hsr_pkg::WORD_W-1:0]    in_rad,
    input  logic [hsr_pkg::WORD_W-1:0]    in_div,
    input  logic [hsr_pkg::WORD_W-1:0]    in_quo,
    input  logic                          in_ovf,
    output logic                          out_vld,
    output logic [hsr_pkg::WORD_W-1:0]    out_rad,
    output logic [hsr_pkg::WORD_W-1:0]    out_est
);
    localparam int W = hsr_pkg::WORD_W;

    logic          vld_reg;
    logic [W-1:0]  rad_reg, est_reg;
    logic [W-1:0]  quo_sat;
    logic [W:0]    sum;

    assign quo_sat = in_ovf ? hsr_pkg::WORD_MAX : in_quo;
    assign sum     = {1'b0, in_div} + {1'b0, quo_sat};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= in_rad;
            est_reg <= sum[W:1];
        end
    end

    assign out_vld = vld_reg;
    assign out_rad = rad_reg;
    assign out_est = est_reg;
endmodule
